/* hdl/assert_macros.svh */
// assertion macros shared by the checker modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is held
`define EZR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion that also runs during reset
`define EZR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hdl/ezr_pkg.sv */
// shared types, constants and helpers for the z-x-y rotation matrix unit
// no dependencies
package ezr_pkg;

  localparam int ANGLE_W        = 16;
  localparam int ELEM_W         = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int NUM_LANES  = 3;
  localparam int LANE_YAW   = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_PITCH = 2;

  localparam int CORDIC_STEPS = 30;
  localparam int TURN_W       = 32;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int CS_W         = 32;
  localparam int PROD_W       = 2 * CS_W;
  localparam int Q_FRAC       = 30;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [TURN_W-1:0]      EIGHTH_TURN = 32'h2000_0000;
  localparam logic signed [Z_W-1:0]  Z_EIGHTH    = 33'sd536870912;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [Z_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
    33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
    33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2F9,
    33'sh0000517C, 33'sh000028BE, 33'sh0000145F, 33'sh00000A2F, 33'sh00000517,
    33'sh0000028B, 33'sh00000145, 33'sh000000A2, 33'sh00000051, 33'sh00000028,
    33'sh00000014, 33'sh0000000A, 33'sh00000005, 33'sh00000002, 33'sh00000001
  };

  localparam int SC_LATENCY  = CORDIC_STEPS + 2;
  localparam int MAT_LATENCY = 5;
  localparam int LATENCY     = SC_LATENCY + MAT_LATENCY;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } out_word_t;

  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
  } trig_t;

  // q2.30 product rounded half up, floor shift
  function automatic logic signed [CS_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + (PROD_W'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
    return t[CS_W-1:0];
  endfunction

endpackage

/* hdl/euler_zxy_rotation_matrix_unit.sv */
// z-x-y rotation matrix from yaw, roll and pitch motor angles
// depends on ezr_pkg and ezr_sincos
//
// One angle word is taken in every clock cycle: busy is always low. Each word gives one
// matrix word, shown for one cycle with out_valid; the receiver cannot hold it off. The
// sine/cosine pipeline has one stage per cordic step plus angle and quadrant stages, and is
// followed by the product, rounding and saturation stages. Elements are signed 16-bit with
// FRAC_BITS fraction bits (q2.14 by default), saturated to plus or minus one.
module euler_zxy_rotation_matrix_unit #(
  parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = ezr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ezr_pkg::in_word_t  in_word,
  output logic               out_valid,
  output ezr_pkg::out_word_t out_word
);

  localparam int LANES  = ezr_pkg::NUM_LANES;
  localparam int CS_W   = ezr_pkg::CS_W;
  localparam int PROD_W = ezr_pkg::PROD_W;
  localparam int M_W    = CS_W + 1;
  localparam int T_W    = M_W + 2;
  localparam int ELEM_W = ezr_pkg::ELEM_W;

  localparam int OUT_SH = ezr_pkg::Q_FRAC - FRAC_BITS;
  localparam logic signed [T_W-1:0] OUT_RND = T_W'((64'sd1 <<< OUT_SH) >>> 1);
  localparam logic signed [T_W-1:0] OUT_ONE = T_W'(64'sd1 <<< FRAC_BITS);

  // first-level products
  localparam int P_C1C3 = 0;
  localparam int P_S1S2 = 1;
  localparam int P_C3S1 = 2;
  localparam int P_C1S2 = 3;
  localparam int P_C2S1 = 4;
  localparam int P_C1C2 = 5;
  localparam int P_S1S3 = 6;
  localparam int P_C2S3 = 7;
  localparam int P_C2C3 = 8;
  localparam int P_C1S3 = 9;
  localparam int NUM_P1 = 10;

  // second-level products
  localparam int Q_S1S2_S3 = 0;
  localparam int Q_C3S1_S2 = 1;
  localparam int Q_C1S2_S3 = 2;
  localparam int Q_C1C3_S2 = 3;
  localparam int NUM_P2    = 4;

  localparam int E_M00 = 0;
  localparam int E_M01 = 1;
  localparam int E_M02 = 2;
  localparam int E_M10 = 3;
  localparam int E_M11 = 4;
  localparam int E_M12 = 5;
  localparam int E_M20 = 6;
  localparam int E_M21 = 7;
  localparam int E_M22 = 8;
  localparam int NUM_E = 9;

  logic                                       accept;
  logic [LANES-1:0][ezr_pkg::ANGLE_W-1:0]     angle;
  logic                                       sc_valid;
  ezr_pkg::trig_t [LANES-1:0]                 trig;

  logic signed [CS_W-1:0]   c1, s1, c2, s2, c3, s3;
  logic signed [CS_W-1:0]   fa [NUM_P1];
  logic signed [CS_W-1:0]   fb [NUM_P1];

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [PROD_W-1:0] p1_r   [NUM_P1];
  logic signed [CS_W-1:0]   s2_1_r, s3_1_r;
  logic signed [CS_W-1:0]   r1_r   [NUM_P1];
  logic signed [CS_W-1:0]   s2_2_r, s3_2_r;
  logic signed [PROD_W-1:0] p2_r   [NUM_P2];
  logic signed [CS_W-1:0]   r1_3_r [NUM_P1];
  logic signed [CS_W-1:0]   s2_3_r;
  logic signed [M_W-1:0]    m_nxt  [NUM_E];
  logic signed [M_W-1:0]    m_r    [NUM_E];
  ezr_pkg::out_word_t       out_word_nxt;
  ezr_pkg::out_word_t       out_word_r;

  function automatic logic [ELEM_W-1:0] to_elem(input logic signed [M_W-1:0] v);
    logic signed [T_W-1:0] t;
    t = (T_W'(v) + OUT_RND) >>> OUT_SH;
    if (t > OUT_ONE) begin
      t = OUT_ONE;
    end else if (t < -OUT_ONE) begin
      t = -OUT_ONE;
    end
    return t[ELEM_W-1:0];
  endfunction

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign angle[ezr_pkg::LANE_YAW]   = in_word.yaw_angle;
  assign angle[ezr_pkg::LANE_ROLL]  = in_word.roll_angle;
  assign angle[ezr_pkg::LANE_PITCH] = in_word.pitch_angle;

  ezr_sincos #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (angle),
    .out_valid (sc_valid),
    .out_trig  (trig)
  );

  assign c1 = trig[ezr_pkg::LANE_YAW].c;
  assign s1 = trig[ezr_pkg::LANE_YAW].s;
  assign c2 = trig[ezr_pkg::LANE_ROLL].c;
  assign s2 = trig[ezr_pkg::LANE_ROLL].s;
  assign c3 = trig[ezr_pkg::LANE_PITCH].c;
  assign s3 = trig[ezr_pkg::LANE_PITCH].s;

  always_comb begin
    fa[P_C1C3] = c1;  fb[P_C1C3] = c3;
    fa[P_S1S2] = s1;  fb[P_S1S2] = s2;
    fa[P_C3S1] = c3;  fb[P_C3S1] = s1;
    fa[P_C1S2] = c1;  fb[P_C1S2] = s2;
    fa[P_C2S1] = c2;  fb[P_C2S1] = s1;
    fa[P_C1C2] = c1;  fb[P_C1C2] = c2;
    fa[P_S1S3] = s1;  fb[P_S1S3] = s3;
    fa[P_C2S3] = c2;  fb[P_C2S3] = s3;
    fa[P_C2C3] = c2;  fb[P_C2C3] = c3;
    fa[P_C1S3] = c1;  fb[P_C1S3] = s3;
  end

  // sums of rounded products
  always_comb begin
    m_nxt[E_M00] = M_W'(r1_3_r[P_C1C3]) - M_W'(ezr_pkg::round_q30(p2_r[Q_S1S2_S3]));
    m_nxt[E_M01] = -M_W'(r1_3_r[P_C2S1]);
    m_nxt[E_M02] = M_W'(r1_3_r[P_C1S3]) + M_W'(ezr_pkg::round_q30(p2_r[Q_C3S1_S2]));
    m_nxt[E_M10] = M_W'(r1_3_r[P_C3S1]) + M_W'(ezr_pkg::round_q30(p2_r[Q_C1S2_S3]));
    m_nxt[E_M11] = M_W'(r1_3_r[P_C1C2]);
    m_nxt[E_M12] = M_W'(r1_3_r[P_S1S3]) - M_W'(ezr_pkg::round_q30(p2_r[Q_C1C3_S2]));
    m_nxt[E_M20] = -M_W'(r1_3_r[P_C2S3]);
    m_nxt[E_M21] = M_W'(s2_3_r);
    m_nxt[E_M22] = M_W'(r1_3_r[P_C2C3]);
  end

  always_comb begin
    out_word_nxt.m00 = to_elem(m_r[E_M00]);
    out_word_nxt.m01 = to_elem(m_r[E_M01]);
    out_word_nxt.m02 = to_elem(m_r[E_M02]);
    out_word_nxt.m10 = to_elem(m_r[E_M10]);
    out_word_nxt.m11 = to_elem(m_r[E_M11]);
    out_word_nxt.m12 = to_elem(m_r[E_M12]);
    out_word_nxt.m20 = to_elem(m_r[E_M20]);
    out_word_nxt.m21 = to_elem(m_r[E_M21]);
    out_word_nxt.m22 = to_elem(m_r[E_M22]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= sc_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_P1; k++) begin
      p1_r[k]   <= fa[k] * fb[k];
      r1_r[k]   <= ezr_pkg::round_q30(p1_r[k]);
      r1_3_r[k] <= r1_r[k];
    end
    s2_1_r <= s2;
    s3_1_r <= s3;
    s2_2_r <= s2_1_r;
    s3_2_r <= s3_1_r;
    s2_3_r <= s2_2_r;
    p2_r[Q_S1S2_S3] <= r1_r[P_S1S2] * s3_2_r;
    p2_r[Q_C3S1_S2] <= r1_r[P_C3S1] * s2_2_r;
    p2_r[Q_C1S2_S3] <= r1_r[P_C1S2] * s3_2_r;
    p2_r[Q_C1C3_S2] <= r1_r[P_C1C3] * s2_2_r;
    for (int e = 0; e < NUM_E; e++) begin
      m_r[e] <= m_nxt[e];
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = v5_r;
  assign out_word  = out_word_r;

endmodule

/* hdl/ezr_sincos.sv */
// pipelined cordic sine and cosine for the three angle lanes
// depends on ezr_pkg
module ezr_sincos #(
  parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic [ezr_pkg::NUM_LANES-1:0][ezr_pkg::ANGLE_W-1:0] in_angle,
  output logic                                          out_valid,
  output ezr_pkg::trig_t [ezr_pkg::NUM_LANES-1:0]       out_trig
);

  localparam int STEPS = ezr_pkg::CORDIC_STEPS;
  localparam int LANES = ezr_pkg::NUM_LANES;
  localparam int XY_W  = ezr_pkg::XY_W;
  localparam int Z_W   = ezr_pkg::Z_W;
  localparam int CS_W  = ezr_pkg::CS_W;
  localparam int TW    = ezr_pkg::TURN_W;
  localparam logic [TW-1:0] ANGLE_MASK = TW'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int TURN_SH = TW - ANGLE_BITS;

  logic [TW-1:0]           shifted   [LANES];
  logic signed [Z_W-1:0]   z_start   [LANES];

  logic                    v_r [0:STEPS];
  logic signed [XY_W-1:0]  x_r [0:STEPS][LANES];
  logic signed [XY_W-1:0]  y_r [0:STEPS][LANES];
  logic signed [Z_W-1:0]   z_r [0:STEPS][LANES];
  logic [1:0]              q_r [0:STEPS][LANES];

  logic signed [XY_W-1:0]  x_nxt [STEPS][LANES];
  logic signed [XY_W-1:0]  y_nxt [STEPS][LANES];
  logic signed [Z_W-1:0]   z_nxt [STEPS][LANES];

  ezr_pkg::trig_t [LANES-1:0] trig_nxt;
  ezr_pkg::trig_t [LANES-1:0] trig_r;
  logic                       out_valid_r;

  // angle to quadrant and residual
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shifted[l] = ((TW'(in_angle[l]) & ANGLE_MASK) << TURN_SH) + ezr_pkg::EIGHTH_TURN;
      z_start[l] = $signed({3'b000, shifted[l][TW-3:0]}) - ezr_pkg::Z_EIGHTH;
    end
  end

  // one micro-rotation per stage
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      for (int l = 0; l < LANES; l++) begin
        if (z_r[i][l] >= 0) begin
          x_nxt[i][l] = x_r[i][l] - (y_r[i][l] >>> i);
          y_nxt[i][l] = y_r[i][l] + (x_r[i][l] >>> i);
          z_nxt[i][l] = z_r[i][l] - ezr_pkg::ATAN_TURN[i];
        end else begin
          x_nxt[i][l] = x_r[i][l] + (y_r[i][l] >>> i);
          y_nxt[i][l] = y_r[i][l] - (x_r[i][l] >>> i);
          z_nxt[i][l] = z_r[i][l] + ezr_pkg::ATAN_TURN[i];
        end
      end
    end
  end

  // quadrant rotation
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (q_r[STEPS][l])
        ezr_pkg::QUAD_0: begin
          trig_nxt[l].c = CS_W'(x_r[STEPS][l]);
          trig_nxt[l].s = CS_W'(y_r[STEPS][l]);
        end
        ezr_pkg::QUAD_1: begin
          trig_nxt[l].c = CS_W'(-y_r[STEPS][l]);
          trig_nxt[l].s = CS_W'(x_r[STEPS][l]);
        end
        ezr_pkg::QUAD_2: begin
          trig_nxt[l].c = CS_W'(-x_r[STEPS][l]);
          trig_nxt[l].s = CS_W'(-y_r[STEPS][l]);
        end
        default: begin
          trig_nxt[l].c = CS_W'(y_r[STEPS][l]);
          trig_nxt[l].s = CS_W'(-x_r[STEPS][l]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STEPS; i++) begin
        v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 0; i < STEPS; i++) begin
        v_r[i+1] <= v_r[i];
      end
      out_valid_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      x_r[0][l] <= ezr_pkg::CORDIC_GAIN;
      y_r[0][l] <= '0;
      z_r[0][l] <= z_start[l];
      q_r[0][l] <= shifted[l][TW-1:TW-2];
    end
    for (int i = 0; i < STEPS; i++) begin
      for (int l = 0; l < LANES; l++) begin
        x_r[i+1][l] <= x_nxt[i][l];
        y_r[i+1][l] <= y_nxt[i][l];
        z_r[i+1][l] <= z_nxt[i][l];
        q_r[i+1][l] <= q_r[i][l];
      end
    end
    trig_r <= trig_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_trig  = trig_r;

endmodule

/* hdl/ezr_checker.sv */
// port-level checker for the z-x-y rotation matrix unit, bound to the top level
// depends on ezr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ezr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LAT = ezr_pkg::LATENCY;

  // every accepted word comes out after the fixed latency
  `EZR_ASSERT(a_word_out, (start && !busy) |-> ##LAT out_valid, "accepted word not delivered")

  // no result without an accepted word the fixed latency earlier
  `EZR_ASSERT(a_no_extra, out_valid |-> $past(start && !busy, LAT), "result without a word")

  // reset clears the result strobe
  `EZR_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

bind euler_zxy_rotation_matrix_unit ezr_checker u_ezr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
